// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is applied
`define RMQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that is also checked during reset
`define RMQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// types and constants for the rotation matrix to quaternion converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int ELEM_W   = 16;
    localparam int N_ELEM   = 9;
    localparam int MAT_W    = ELEM_W * N_ELEM;
    localparam int TRACE_W  = 19;
    localparam int MAG_W    = 17;
    localparam int GAIN_SH  = 12;
    localparam int RAD_W    = 30;
    localparam int REM_W    = 17;
    localparam int ROOT_W   = 15;
    localparam int N_CELLS  = RAD_W / 2;
    localparam int N_LANES  = 4;
    localparam int N_AXES   = 3;
    localparam int QW_W     = 15;
    localparam int QV_W     = 16;
    localparam int QUAT_W   = 64;
    localparam int Q_ONE    = 16384;

    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } lane_t;

    typedef struct packed {
        lane_t [N_LANES-1:0] lane;
        logic  [N_AXES-1:0]  dzero;
        logic  [N_AXES-1:0]  dneg;
    } pipe_t;

endpackage

// ===== hdl/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// trace combinations, clamp and gain, off-diagonal signs, input register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmq_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [rmq_pkg::MAT_W-1:0] in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rmq_pkg::pipe_t            out_data
);
    import rmq_pkg::*;

    function automatic logic [RAD_W-1:0] to_rad(input logic signed [TRACE_W-1:0] a);
        logic [RAD_W-1:0] r;
        if (a[TRACE_W-1])
        begin
            r = '0;
        end
        else
        begin
            r = {1'b0, a[MAG_W-1:0], {GAIN_SH{1'b0}}};
        end
        return r;
    endfunction

    logic signed [TRACE_W-1:0] m [N_ELEM];
    logic signed [TRACE_W-1:0] a_w, a_x, a_y, a_z;
    logic signed [TRACE_W-1:0] d [N_AXES];
    logic signed [TRACE_W-1:0] one;
    pipe_t                     data_next;
    pipe_t                     data_reg;
    logic                      valid_next;
    logic                      valid_reg;

    always_comb
    begin
        for (int k = 0; k < N_ELEM; k++)
        begin
            m[k] = TRACE_W'($signed(in_data[k*ELEM_W +: ELEM_W]));
        end
    end

    assign one = TRACE_W'(Q_ONE);
    assign a_w = one + m[0] + m[4] + m[8];
    assign a_x = one + m[0] - m[4] - m[8];
    assign a_y = one - m[0] + m[4] - m[8];
    assign a_z = one - m[0] - m[4] + m[8];

    // x: m21 - m12, y: m02 - m20, z: m10 - m01
    assign d[0] = m[7] - m[5];
    assign d[1] = m[2] - m[6];
    assign d[2] = m[3] - m[1];

    always_comb
    begin
        data_next.lane[LANE_W] = '{rad: to_rad(a_w), rem: '0, root: '0};
        data_next.lane[LANE_X] = '{rad: to_rad(a_x), rem: '0, root: '0};
        data_next.lane[LANE_Y] = '{rad: to_rad(a_y), rem: '0, root: '0};
        data_next.lane[LANE_Z] = '{rad: to_rad(a_z), rem: '0, root: '0};
        for (int k = 0; k < N_AXES; k++)
        begin
            data_next.dzero[k] = (d[k] == '0);
            data_next.dneg[k]  = d[k][TRACE_W-1];
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/rmq_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_cell
// one square-root cell: settles one root bit in each of the four lanes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmq_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rmq_pkg::pipe_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rmq_pkg::pipe_t out_data
);
    import rmq_pkg::*;

    pipe_t            data_next;
    pipe_t            data_reg;
    logic             valid_next;
    logic             valid_reg;
    logic [REM_W-1:0] rem_sh [N_LANES];
    logic [REM_W-1:0] trial  [N_LANES];
    logic             ge     [N_LANES];

    always_comb
    begin
        data_next = in_data;
        for (int k = 0; k < N_LANES; k++)
        begin
            // bring down the next two radicand bits
            rem_sh[k] = {in_data.lane[k].rem[REM_W-3:0], in_data.lane[k].rad[RAD_W-1 -: 2]};
            trial[k]  = {in_data.lane[k].root, 2'b01};
            ge[k]     = (rem_sh[k] >= trial[k]);
            data_next.lane[k].rad  = {in_data.lane[k].rad[RAD_W-3:0], 2'b00};
            data_next.lane[k].rem  = ge[k] ? (rem_sh[k] - trial[k]) : rem_sh[k];
            data_next.lane[k].root = {in_data.lane[k].root[ROOT_W-2:0], ge[k]};
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/rmq_back.sv =====
// ----------------------------------------------------------------------------
// rmq_back
// applies the off-diagonal signs and holds the result for the output side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmq_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  rmq_pkg::pipe_t             in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rmq_pkg::QUAT_W-1:0] out_data
);
    import rmq_pkg::*;

    logic [QV_W-1:0]   mag [N_AXES];
    logic [QV_W-1:0]   vec [N_AXES];
    logic [QUAT_W-1:0] data_next;
    logic [QUAT_W-1:0] data_reg;
    logic              valid_next;
    logic              valid_reg;

    always_comb
    begin
        for (int k = 0; k < N_AXES; k++)
        begin
            mag[k] = {1'b0, in_data.lane[k+1].root};
            priority if (in_data.dzero[k])
            begin
                vec[k] = '0;
            end
            else if (in_data.dneg[k])
            begin
                vec[k] = -mag[k];
            end
            else
            begin
                vec[k] = mag[k];
            end
        end
        data_next = {1'b0, vec[2], vec[1], vec[0], in_data.lane[LANE_W].root[QW_W-1:0]};
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 rotation matrix in Q2.14 to quaternion (w, x, y, z), w in unsigned Q1.14, x, y, z in Q2.14
// ----------------------------------------------------------------------------
// Takes one matrix request per cycle and returns one quaternion per cycle while
// the output side does not stall. The path is the square-root chain: a front
// register forms the four trace combinations, 15 identical cells each settle
// one root bit for all four components, and an output register applies the
// signs of the off-diagonal differences. Every stage has its own valid flag
// and takes new data as soon as its neighbor moves on, so bubbles close up and
// a stall on the output side backs up stage by stage.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each
    input  logic [rmq_pkg::MAT_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // quat_w[14:0], quat_x[30:15], quat_y[46:31], quat_z[62:47], zero[63]
    output logic [rmq_pkg::QUAT_W-1:0] m_axis_tdata
);
    import rmq_pkg::*;

    pipe_t stage_data  [N_CELLS+1];
    logic  stage_valid [N_CELLS+1];
    logic  stage_ready [N_CELLS+1];

    rmq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        rmq_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    rmq_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[N_CELLS]),
        .in_ready  (stage_ready[N_CELLS]),
        .in_data   (stage_data[N_CELLS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== hdl/rmq_checker.sv =====
// ----------------------------------------------------------------------------
// rmq_checker
// port-level checks for the rotation matrix to quaternion converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmq_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [rmq_pkg::MAT_W-1:0]  s_axis_tdata,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [rmq_pkg::QUAT_W-1:0] m_axis_tdata
);
    import rmq_pkg::*;

    logic signed [QV_W-1:0] qx, qy, qz;
    logic        [QW_W-1:0] qw;
    logic                   in_wait;
    logic                   out_wait;
    logic                   w_ok;
    logic                   v_ok;

    assign qw = m_axis_tdata[QW_W-1:0];
    assign qx = m_axis_tdata[QW_W +: QV_W];
    assign qy = m_axis_tdata[QW_W+QV_W +: QV_W];
    assign qz = m_axis_tdata[QW_W+2*QV_W +: QV_W];

    assign in_wait  = s_axis_tvalid && !s_axis_tready;
    assign out_wait = m_axis_tvalid && !m_axis_tready;
    assign w_ok     = (qw <= 15'd21674) && !m_axis_tdata[QUAT_W-1];
    assign v_ok     = (qx <= 16'sd21674) && (qx >= -16'sd21674)
                   && (qy <= 16'sd21674) && (qy >= -16'sd21674)
                   && (qz <= 16'sd21674) && (qz >= -16'sd21674);

    `RMQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !m_axis_tvalid, "result valid during reset")
    `RMQ_ASSERT(a_in_hold, in_wait |=> s_axis_tvalid && $stable(s_axis_tdata), "request dropped")
    `RMQ_ASSERT(a_hold, out_wait |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
    `RMQ_ASSERT(a_w_range, m_axis_tvalid |-> w_ok, "w out of range")
    `RMQ_ASSERT(a_v_range, m_axis_tvalid |-> v_ok, "vector part out of range")

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/quat_check_pkg.sv =====
// ----------------------------------------------------------------------------
// quat_check_pkg
// expected-quaternion store and field checker for the matrix converter bench
// ----------------------------------------------------------------------------
// Each accepted matrix request is turned into the quaternion that the
// converter must return and queued. Results from the output stream are
// compared field by field against the oldest queued quaternion.
`timescale 1ns / 1ps

package quat_check_pkg;

    import rmq_pkg::*;

    localparam int M00 = 0;
    localparam int M01 = 1;
    localparam int M02 = 2;
    localparam int M10 = 3;
    localparam int M11 = 4;
    localparam int M12 = 5;
    localparam int M20 = 6;
    localparam int M21 = 7;
    localparam int M22 = 8;

    localparam int SQRT_SCALE = 4096;

    typedef logic signed [ELEM_W-1:0] matrix_t [N_ELEM];

    typedef struct {
        logic        [QW_W-1:0] w;
        logic signed [QV_W-1:0] x;
        logic signed [QV_W-1:0] y;
        logic signed [QV_W-1:0] z;
        logic                   pad;
    } quat_t;

    class quat_scoreboard;

        quat_t       pending_quats[$];
        int unsigned matrices_noted;
        int unsigned quats_checked;
        int unsigned mismatches;

        // floor of sqrt(4096 * a), zero for a non-positive trace term
        function automatic int unsigned half_root_q14(int a);
            longint unsigned n;
            longint unsigned trial;
            int unsigned     root;
            root = 0;
            if (a <= 0)
                return 0;
            n = longint'(a) * SQRT_SCALE;
            for (int b = 15; b >= 0; b--)
            begin
                trial = root | (32'd1 << b);
                if (trial * trial <= n)
                    root = int'(trial);
            end
            return root;
        endfunction

        function automatic logic signed [QV_W-1:0] apply_sign(int unsigned mag, int diff);
            int v;
            if (diff == 0)
                v = 0;
            else if (diff < 0)
                v = -int'(mag);
            else
                v = int'(mag);
            return v[QV_W-1:0];
        endfunction

        function automatic quat_t predict_quat(matrix_t m);
            quat_t q;
            int    d00, d11, d22;
            int unsigned mw, mx, my, mz;
            d00 = m[M00];
            d11 = m[M11];
            d22 = m[M22];
            mw = half_root_q14(Q_ONE + d00 + d11 + d22);
            mx = half_root_q14(Q_ONE + d00 - d11 - d22);
            my = half_root_q14(Q_ONE - d00 + d11 - d22);
            mz = half_root_q14(Q_ONE - d00 - d11 + d22);
            q.w   = mw[QW_W-1:0];
            q.x   = apply_sign(mx, int'(m[M21]) - int'(m[M12]));
            q.y   = apply_sign(my, int'(m[M02]) - int'(m[M20]));
            q.z   = apply_sign(mz, int'(m[M10]) - int'(m[M01]));
            q.pad = 1'b0;
            return q;
        endfunction

        function void note_matrix(matrix_t m);
            pending_quats.insert(pending_quats.size(), predict_quat(m));
            matrices_noted++;
        endfunction

        function void check_quat(logic [QUAT_W-1:0] data);
            quat_t want;
            quat_t got;
            if (pending_quats.size() == 0)
            begin
                $display("%0t: quaternion %h arrived with no request waiting", $time, data);
                mismatches++;
                return;
            end
            want = pending_quats.pop_front();
            got.w   = data[14:0];
            got.x   = data[30:15];
            got.y   = data[46:31];
            got.z   = data[62:47];
            got.pad = data[63];
            quats_checked++;
            if (got.w !== want.w)
            begin
                $display("%0t: quat_w expected %0d actual %0d", $time, want.w, got.w);
                mismatches++;
            end
            if (got.x !== want.x)
            begin
                $display("%0t: quat_x expected %0d actual %0d", $time, want.x, got.x);
                mismatches++;
            end
            if (got.y !== want.y)
            begin
                $display("%0t: quat_y expected %0d actual %0d", $time, want.y, got.y);
                mismatches++;
            end
            if (got.z !== want.z)
            begin
                $display("%0t: quat_z expected %0d actual %0d", $time, want.z, got.z);
                mismatches++;
            end
            if (got.pad !== want.pad)
            begin
                $display("%0t: pad bit expected %b actual %b", $time, want.pad, got.pad);
                mismatches++;
            end
        endfunction

        function void report_leftover();
            if (pending_quats.size() != 0)
            begin
                $display("%0t: %0d expected quaternions never arrived",
                         $time, pending_quats.size());
                mismatches += pending_quats.size();
            end
        endfunction

    endclass

endpackage

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// stream-level check of the rotation matrix to quaternion converter
// ----------------------------------------------------------------------------
// Sends directed corner matrices, then proper rotations, random bit patterns,
// symmetric matrices and matrices of corner values, with random gaps on the
// request side and random back-pressure on the result side. Every result is
// compared with a quaternion worked out from the same request.
`timescale 1ns / 1ps

module testbench;

    import rmq_pkg::*;
    import quat_check_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    localparam int IDLE_PCT     = 28;
    localparam int RANDOM_ITEMS = 430;
    localparam int QUIET_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 40;
    localparam int STUCK_LIMIT  = 5000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [MAT_W-1:0]   s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [QUAT_W-1:0]  m_axis_tdata;

    logic               calm = 1'b0;
    int unsigned        directed_sent;
    int unsigned        random_sent;
    matrix_t            corners [$];

    quat_scoreboard     sb = new;

    rotation_matrix_to_quaternion u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_quat(m_axis_tdata);
    end

    initial
    begin
        int stuck;
        stuck = 0;
        wait (rst_n);
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: no request or result moved for %0d cycles", $time, STUCK_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic matrix_t make_matrix(int a00, int a01, int a02,
                                            int a10, int a11, int a12,
                                            int a20, int a21, int a22);
        matrix_t m;
        m[M00] = a00[15:0]; m[M01] = a01[15:0]; m[M02] = a02[15:0];
        m[M10] = a10[15:0]; m[M11] = a11[15:0]; m[M12] = a12[15:0];
        m[M20] = a20[15:0]; m[M21] = a21[15:0]; m[M22] = a22[15:0];
        return m;
    endfunction

    function automatic void add_corner(input matrix_t m);
        corners.insert(corners.size(), m);
    endfunction

    // proper rotation from a random quaternion, with a little noise
    function automatic matrix_t random_rotation();
        matrix_t m;
        real     qa, qb, qc, qd, nrm;
        real     rot [N_ELEM];
        qa = real'(int'($urandom_range(0, 2000)) - 1000);
        qb = real'(int'($urandom_range(0, 2000)) - 1000);
        qc = real'(int'($urandom_range(0, 2000)) - 1000);
        qd = real'(int'($urandom_range(0, 2000)) - 1000);
        nrm = $sqrt(qa * qa + qb * qb + qc * qc + qd * qd);
        if (nrm == 0.0)
        begin
            qa = 1.0;
            nrm = 1.0;
        end
        qa = qa / nrm; qb = qb / nrm; qc = qc / nrm; qd = qd / nrm;
        rot[M00] = 1.0 - 2.0 * (qc * qc + qd * qd);
        rot[M01] = 2.0 * (qb * qc - qa * qd);
        rot[M02] = 2.0 * (qb * qd + qa * qc);
        rot[M10] = 2.0 * (qb * qc + qa * qd);
        rot[M11] = 1.0 - 2.0 * (qb * qb + qd * qd);
        rot[M12] = 2.0 * (qc * qd - qa * qb);
        rot[M20] = 2.0 * (qb * qd - qa * qc);
        rot[M21] = 2.0 * (qc * qd + qa * qb);
        rot[M22] = 1.0 - 2.0 * (qb * qb + qc * qc);
        for (int i = 0; i < N_ELEM; i++)
            m[i] = 16'($rtoi(rot[i] * 16384.0) + int'($urandom_range(0, 6)) - 3);
        return m;
    endfunction

    function automatic matrix_t random_item();
        matrix_t m;
        int      kind;
        int      corner [5];
        kind = $urandom_range(99);
        corner[0] = -32768; corner[1] = 32767; corner[2] = 0;
        corner[3] = Q_ONE;  corner[4] = -Q_ONE;
        if (kind < 55)
            m = random_rotation();
        else if (kind < 75)
        begin
            for (int i = 0; i < N_ELEM; i++)
                m[i] = 16'($urandom());
        end
        else if (kind < 88)
        begin
            // symmetric off-diagonals, so some signs collapse to zero
            for (int i = 0; i < N_ELEM; i++)
                m[i] = 16'(int'($urandom_range(0, 40000)) - 20000);
            m[M10] = m[M01];
            if ($urandom_range(1))
                m[M20] = m[M02];
            if ($urandom_range(1))
                m[M21] = m[M12];
        end
        else
        begin
            for (int i = 0; i < N_ELEM; i++)
                m[i] = 16'(corner[$urandom_range(4)]);
        end
        return m;
    endfunction

    task automatic send_matrix(input matrix_t m);
        logic [MAT_W-1:0] flat;
        for (int i = 0; i < N_ELEM; i++)
            flat[i*ELEM_W +: ELEM_W] = m[i];
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= flat;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_matrix(m);
    endtask

    task automatic hold_requests();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (sb.pending_quats.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        add_corner(make_matrix(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE));
        add_corner(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_corner(make_matrix(32767, 32767, 32767, 32767, 32767,
                               32767, 32767, 32767, 32767));
        add_corner(make_matrix(-32768, -32768, -32768, -32768, -32768,
                               -32768, -32768, -32768, -32768));
        // each trace term at its largest, with the matching off-diagonal differences at full swing
        add_corner(make_matrix(32767, 0, 0, 0, -32768, -32768, 0, 32767, -32768));
        add_corner(make_matrix(-32768, 0, -32768, 0, 32767, 0, 32767, 0, -32768));
        add_corner(make_matrix(-32768, 32767, 0, -32768, -32768, 0, 0, 0, 32767));
        add_corner(make_matrix(32767, -32768, 32767, 32767, 32767,
                               32767, -32768, -32768, 32767));
        // quarter turns about each axis, both directions
        add_corner(make_matrix(Q_ONE, 0, 0, 0, 0, -Q_ONE, 0, Q_ONE, 0));
        add_corner(make_matrix(0, 0, Q_ONE, 0, Q_ONE, 0, -Q_ONE, 0, 0));
        add_corner(make_matrix(0, -Q_ONE, 0, Q_ONE, 0, 0, 0, 0, Q_ONE));
        add_corner(make_matrix(Q_ONE, 0, 0, 0, 0, Q_ONE, 0, -Q_ONE, 0));
        add_corner(make_matrix(0, 0, -Q_ONE, 0, Q_ONE, 0, Q_ONE, 0, 0));
        add_corner(make_matrix(0, Q_ONE, 0, -Q_ONE, 0, 0, 0, 0, Q_ONE));
        // half turns: w is zero and the equal off-diagonals zero the vector part
        add_corner(make_matrix(Q_ONE, 0, 0, 0, -Q_ONE, 0, 0, 0, -Q_ONE));
        add_corner(make_matrix(-Q_ONE, 0, 0, 0, -Q_ONE, 0, 0, 0, Q_ONE));
        // negative trace, clamped to zero
        add_corner(make_matrix(-Q_ONE, 0, 0, 0, -Q_ONE, 0, 0, 0, -Q_ONE));
        // equal nonzero off-diagonal pairs
        add_corner(make_matrix(100, 5000, -7000, 5000, 200, 9000, -7000, 9000, 300));
        // smallest positive trace term
        add_corner(make_matrix(-16383, 1, -1, -1, 0, 1, 1, -1, 0));
        add_corner(make_matrix(0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0));
        add_corner(make_matrix(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                               16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
        add_corner(make_matrix(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                               16'h5555, 16'haaaa, 16'h5555, 16'haaaa));

        foreach (corners[i])
        begin
            send_matrix(corners[i]);
            directed_sent++;
        end

        // let the pipe run dry before the random part
        hold_requests();
        wait_for_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 150) && (n < 150 + QUIET_ITEMS);
            send_matrix(random_item());
            random_sent++;
        end
        calm = 1'b0;
        hold_requests();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.report_leftover();

        $display("covered %0d corner matrices and %0d random matrices", directed_sent,
                 random_sent);
        $display("%0d quaternions compared, %0d field mismatches", sb.quats_checked,
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
